>>> rtl/core/deq_pkg.sv
// Package for the double-ended queue: sizes, operation and status codes,
// and the request, result and control struct types. No dependencies.
`default_nettype none
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = 5;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_HEAD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_TAIL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_HEAD  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_TAIL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [DATA_WIDTH-1:0] data_in;
  } deq_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [DATA_WIDTH-1:0] data_out;
    logic [CNT_W-1:0]      count;
  } deq_out_t;

  typedef struct packed {
    logic accept;
    logic load_now;
    logic load_rd;
  } deq_cmd_t;

  typedef struct packed {
    logic pop_ok;
  } deq_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/deq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
`default_nettype none
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/deq_ctrl.sv
// Controller for the double-ended queue: request handshake, the wait state
// for a memory read on a successful pop, and the result valid flag. Uses deq_pkg.
`default_nettype none
module deq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire deq_pkg::deq_stat_t stat,
  output deq_pkg::deq_cmd_t      cmd
);
  import deq_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_READ = 1'b1;

  logic [0:0] state_r;
  logic [0:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free      = !out_valid_r || !out_stall;
  assign in_stall      = (state_r != ST_IDLE) || !out_free;
  assign cmd.accept    = in_valid && !in_stall;
  assign cmd.load_now  = cmd.accept && !stat.pop_ok;
  assign cmd.load_rd   = (state_r == ST_READ);
  assign out_valid     = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept && stat.pop_ok) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.load_now || cmd.load_rd) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/deq_dp.sv
// Datapath for the double-ended queue: head and tail indices, entry count,
// the ring memory and the result register. Uses deq_pkg and deq_ram.
`default_nettype none
module deq_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire deq_pkg::deq_in_t   in_data,
  input  wire deq_pkg::deq_cmd_t  cmd,
  output deq_pkg::deq_stat_t      stat,
  output deq_pkg::deq_out_t       out_data
);
  import deq_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [IDX_W-1:0]      front_r, front_nxt;
  logic [IDX_W-1:0]      back_r, back_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      front_inc, front_dec, back_inc, back_dec;
  logic                  is_full, is_empty;
  logic                  push_ok, pop_ok;
  logic [STATUS_W-1:0]   status_now;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  deq_out_t              out_r;
  deq_out_t              out_nxt;

  assign front_inc = (front_r == IDX_LAST) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? IDX_LAST : front_r - 1'b1;
  assign back_inc  = (back_r == IDX_LAST) ? '0 : back_r + 1'b1;
  assign back_dec  = (back_r == '0) ? IDX_LAST : back_r - 1'b1;
  assign is_full   = (count_r >= CNT_FULL);
  assign is_empty  = (count_r == '0);

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    push_ok    = 1'b0;
    pop_ok     = 1'b0;
    status_now = STATUS_DONE;
    wr_addr    = back_r;
    rd_addr    = front_r;
    unique case (in_data.kind)
      KIND_PUSH_HEAD: begin
        if (is_full) begin
          status_now = STATUS_FULL;
        end else begin
          push_ok   = 1'b1;
          wr_addr   = front_dec;
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_PUSH_TAIL: begin
        if (is_full) begin
          status_now = STATUS_FULL;
        end else begin
          push_ok   = 1'b1;
          wr_addr   = back_r;
          back_nxt  = back_inc;
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_POP_HEAD: begin
        if (is_empty) begin
          status_now = STATUS_EMPTY;
        end else begin
          pop_ok    = 1'b1;
          rd_addr   = front_r;
          front_nxt = front_inc;
          count_nxt = count_r - 1'b1;
        end
      end
      KIND_POP_TAIL: begin
        if (is_empty) begin
          status_now = STATUS_EMPTY;
        end else begin
          pop_ok    = 1'b1;
          rd_addr   = back_dec;
          back_nxt  = back_dec;
          count_nxt = count_r - 1'b1;
        end
      end
      KIND_CLEAR: begin
        front_nxt = '0;
        back_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign stat.pop_ok = pop_ok;

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.accept && push_ok),
    .wr_addr (wr_addr),
    .wr_data (in_data.data_in),
    .rd_en   (cmd.accept && pop_ok),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    out_nxt = out_r;
    priority if (cmd.load_rd) begin
      out_nxt.status   = STATUS_DONE;
      out_nxt.data_out = rd_data;
      out_nxt.count    = count_r;
    end else if (cmd.load_now) begin
      out_nxt.status   = status_now;
      out_nxt.data_out = '0;
      out_nxt.count    = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (cmd.accept) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

>>> rtl/core/double_ended_queue_top.sv
// Double-ended queue top level: a 16-entry ring with push and pop at both ends.
// A push, clear or refused pop loads its result register as it is accepted; a
// successful pop first reads the ring memory, then loads the result from it.
// Throughput: one request per cycle, held off by result stalls and pop reads.
// Reset: synchronous active-low rst_n empties the queue; memory contents are kept.
// Depends on deq_pkg, deq_ctrl, deq_dp and deq_ram.
`default_nettype none
module double_ended_queue_top (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire deq_pkg::deq_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output deq_pkg::deq_out_t     out_data
);
  import deq_pkg::*;

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  deq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

>>> sim/deq_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the double-ended queue: watches the request and result
// channels, predicts every result with its own ring model and compares fields.
// Depends on deq_pkg only.
module deq_result_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  deq_pkg::deq_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  deq_pkg::deq_out_t out_data,
  output int                fail_count,
  output int                pending
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] ring_words [DEPTH];
  int unsigned head_slot = 0;
  int unsigned tail_slot = 0;
  int unsigned held = 0;
  deq_out_t results_due [$];
  int mismatches = 0;
  int outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  function automatic int unsigned slot_after(int unsigned s);
    return (s == DEPTH - 1) ? 0 : s + 1;
  endfunction

  function automatic int unsigned slot_before(int unsigned s);
    return (s == 0) ? DEPTH - 1 : s - 1;
  endfunction

  function automatic deq_out_t deque_apply(deq_in_t req);
    deq_out_t res;
    res.status   = STATUS_DONE;
    res.data_out = '0;
    case (req.kind)
      KIND_PUSH_HEAD: begin
        if (held == DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          head_slot = slot_before(head_slot);
          ring_words[head_slot] = req.data_in;
          held++;
        end
      end
      KIND_PUSH_TAIL: begin
        if (held == DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          ring_words[tail_slot] = req.data_in;
          tail_slot = slot_after(tail_slot);
          held++;
        end
      end
      KIND_POP_HEAD: begin
        if (held == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.data_out = ring_words[head_slot];
          head_slot = slot_after(head_slot);
          held--;
        end
      end
      KIND_POP_TAIL: begin
        if (held == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          tail_slot = slot_before(tail_slot);
          res.data_out = ring_words[tail_slot];
          held--;
        end
      end
      KIND_CLEAR: begin
        head_slot = 0;
        tail_slot = 0;
        held      = 0;
      end
      default: begin
      end
    endcase
    res.count = CNT_W'(held);
    return res;
  endfunction

  task automatic report_mismatch(string note);
    $display("%0t ns: %s", $time, note);
    mismatches++;
  endtask

  always @(posedge clk) begin
    deq_out_t want;
    if (!rst_n) begin
      head_slot = 0;
      tail_slot = 0;
      held      = 0;
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result %h arrived with no request outstanding",
                                    out_data));
        end else begin
          want = results_due.pop_front();
          if (out_data.status !== want.status) begin
            report_mismatch($sformatf("status is %0d, expected %0d",
                                      out_data.status, want.status));
          end
          if (out_data.data_out !== want.data_out) begin
            report_mismatch($sformatf("data_out is %h, expected %h",
                                      out_data.data_out, want.data_out));
          end
          if (out_data.count !== want.count) begin
            report_mismatch($sformatf("count is %0d, expected %0d",
                                      out_data.count, want.count));
          end
        end
      end
      if (in_valid && !in_stall) begin
        results_due.push_back(deque_apply(in_data));
      end
    end
    outstanding <= results_due.size();
  end

endmodule

>>> sim/double_ended_queue_top_test.sv
`timescale 1ns / 100ps
// Testbench top for the double-ended queue: drives directed and random requests
// with random gaps and result stalls, and gives the verdict.
// Depends on deq_pkg, double_ended_queue_top and deq_result_checker.
module double_ended_queue_top_test;
  import deq_pkg::*;

  typedef enum int {LEAN_EVEN, LEAN_FILL, LEAN_DRAIN} lean_t;

  localparam int RANDOM_REQUESTS = 2000;
  localparam int CYCLE_LIMIT     = 1_000_000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  deq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  deq_out_t out_data;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int stall_left  = 0;
  int free_left   = 0;
  bit calm        = 1'b0;

  always #10 clk = ~clk;

  double_ended_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  deq_result_checker result_watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic int pick_gap(bit calm_now);
    int roll;
    if (calm_now) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(lean_t lean);
    int roll;
    int push_odds;
    roll = $urandom_range(0, 99);
    push_odds = (lean == LEAN_FILL) ? 75 : (lean == LEAN_DRAIN) ? 25 : 50;
    if (roll < 2) begin
      return KIND_CLEAR;
    end else if (roll < 4) begin
      return KIND_W'(KIND_CLEAR + 1 + $urandom_range(0, 2));
    end else if ($urandom_range(0, 99) < push_odds) begin
      return $urandom_range(0, 1) ? KIND_PUSH_HEAD : KIND_PUSH_TAIL;
    end
    return $urandom_range(0, 1) ? KIND_POP_HEAD : KIND_POP_TAIL;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      return '0;
    end else if (roll < 10) begin
      return '1;
    end
    return DATA_WIDTH'($urandom);
  endfunction

  task automatic issue(logic [KIND_W-1:0] kind, logic [DATA_WIDTH-1:0] word);
    deq_in_t req;
    int gap;
    req.kind    = kind;
    req.data_in = word;
    gap = pick_gap(calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left <= free_left - 1;
    end else begin
      out_stall  <= 1'b0;
      free_left  <= $urandom_range(0, 12);
      stall_left <= pick_gap(calm);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("double_ended_queue_top_test failed");
      $finish;
    end
  end

  initial begin
    lean_t lean;
    int    phase_len;
    int    issued;
    logic [DATA_WIDTH-1:0] word;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Pops on the empty queue are refused, then the queue is filled from both ends.
    issue(KIND_POP_HEAD, '1);
    issue(KIND_POP_TAIL, '0);
    for (int n = 0; n < DEPTH; n++) begin
      case (n)
        0:       word = '0;
        1:       word = '1;
        2:       word = 32'hA5A5_A5A5;
        3:       word = 32'h5A5A_5A5A;
        default: word = DATA_WIDTH'($urandom);
      endcase
      issue(n[0] ? KIND_PUSH_HEAD : KIND_PUSH_TAIL, word);
    end
    issue(KIND_PUSH_HEAD, '1);
    issue(KIND_PUSH_TAIL, '1);
    issue(KIND_POP_HEAD, '0);
    issue(KIND_POP_TAIL, '0);
    issue(KIND_W'(KIND_CLEAR + 1), '1);
    issue(KIND_W'(KIND_CLEAR + 2), '1);
    issue(KIND_W'(KIND_CLEAR + 3), '1);
    issue(KIND_CLEAR, '1);
    issue(KIND_CLEAR, '0);

    issued = 0;
    while (issued < RANDOM_REQUESTS) begin
      lean      = lean_t'($urandom_range(0, 2));
      calm      <= ($urandom_range(0, 5) == 0);
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        issue(pick_kind(lean), pick_word());
        issued++;
      end
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("double_ended_queue_top_test passed");
    end else begin
      $display("double_ended_queue_top_test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_ctrl.sv
rtl/core/deq_dp.sv
rtl/core/double_ended_queue_top.sv
sim/deq_result_checker.sv
sim/double_ended_queue_top_test.sv
